### src/u2rtf_pkg.sv
// ----------------------------------------------------------------------------
// u2rtf_pkg
// Shared types, constants and helpers of the UTF-8 to RTF text escaper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package u2rtf_pkg;

    localparam int MAX_SEQUENCE_BYTES = 4;
    localparam int HELD_DEPTH         = 3;
    localparam int LIST_DEPTH         = HELD_DEPTH + 1;
    localparam int OUT_LIMIT          = 24;
    localparam int DIGIT_DEPTH        = 5;

    localparam logic [15:0] DIV10_RECIP = 16'd52429;
    localparam int          DIV10_SHIFT = 19;

    localparam logic [7:0] ASCII_LIMIT = 8'd128;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;
    localparam logic [7:0] CH_LOWER_U  = 8'h75;
    localparam logic [7:0] CH_DASH     = 8'h2D;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_BLANK    = 8'h20;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_LOAD,
        ST_CONV,
        ST_BS,
        ST_U,
        ST_MINUS,
        ST_DIGIT,
        ST_SPACE,
        ST_PLAIN_BS,
        ST_PLAIN
    } state_t;

    typedef enum logic [1:0] {
        TAIL_NONE,
        TAIL_PLAIN,
        TAIL_PLAIN_ESC,
        TAIL_CODE
    } tail_t;

    typedef enum logic [2:0] {
        SEL_BS,
        SEL_U,
        SEL_MINUS,
        SEL_DIGIT,
        SEL_SPACE,
        SEL_PLAIN
    } char_sel_t;

    typedef struct packed {
        logic      accept;
        logic      esc_load;
        logic      conv_step;
        logic      emit;
        char_sel_t sel;
        logic      final_char;
    } cmd_t;

    typedef struct packed {
        logic  lone_pending;
        tail_t tail;
        logic  esc_neg;
        logic  quot_zero;
        logic  ndig_one;
        logic  out_free;
        logic  at_limit;
    } stat_t;

    // Sequence length announced by a lead byte, zero when it is no lead byte.
    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        len = 3'd0;
        if (b[7:5] == 3'b110)
        begin
            len = 3'd2;
        end
        else if (b[7:4] == 4'b1110)
        begin
            len = 3'd3;
        end
        else if (b[7:3] == 5'b11110)
        begin
            len = 3'd4;
        end
        return len;
    endfunction

endpackage

### src/u2rtf_ctrl.sv
// ----------------------------------------------------------------------------
// u2rtf_ctrl
// Sequencer: walks the escapes and plain characters of one input word and
// drives the datapath one character at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u2rtf_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  u2rtf_pkg::stat_t st,
    output u2rtf_pkg::cmd_t  cmd
);

    u2rtf_pkg::state_t state_reg;
    u2rtf_pkg::state_t state_next;

    logic more;
    logic emit_ok;

    assign more    = st.lone_pending || (st.tail != u2rtf_pkg::TAIL_NONE);
    assign emit_ok = st.out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= u2rtf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            u2rtf_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = u2rtf_pkg::ST_DISPATCH;
                end
            end
            u2rtf_pkg::ST_DISPATCH:
            begin
                if (st.lone_pending || st.tail == u2rtf_pkg::TAIL_CODE)
                begin
                    state_next = u2rtf_pkg::ST_LOAD;
                end
                else if (st.tail == u2rtf_pkg::TAIL_PLAIN_ESC)
                begin
                    state_next = u2rtf_pkg::ST_PLAIN_BS;
                end
                else if (st.tail == u2rtf_pkg::TAIL_PLAIN)
                begin
                    state_next = u2rtf_pkg::ST_PLAIN;
                end
                else
                begin
                    state_next = u2rtf_pkg::ST_IDLE;
                end
            end
            u2rtf_pkg::ST_LOAD:
            begin
                state_next = u2rtf_pkg::ST_CONV;
            end
            u2rtf_pkg::ST_CONV:
            begin
                if (st.quot_zero)
                begin
                    state_next = u2rtf_pkg::ST_BS;
                end
            end
            u2rtf_pkg::ST_BS:
            begin
                if (emit_ok)
                begin
                    state_next = st.at_limit ? u2rtf_pkg::ST_IDLE : u2rtf_pkg::ST_U;
                end
            end
            u2rtf_pkg::ST_U:
            begin
                if (emit_ok)
                begin
                    if (st.at_limit)
                    begin
                        state_next = u2rtf_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = st.esc_neg ? u2rtf_pkg::ST_MINUS : u2rtf_pkg::ST_DIGIT;
                    end
                end
            end
            u2rtf_pkg::ST_MINUS:
            begin
                if (emit_ok)
                begin
                    state_next = st.at_limit ? u2rtf_pkg::ST_IDLE : u2rtf_pkg::ST_DIGIT;
                end
            end
            u2rtf_pkg::ST_DIGIT:
            begin
                if (emit_ok)
                begin
                    if (st.at_limit)
                    begin
                        state_next = u2rtf_pkg::ST_IDLE;
                    end
                    else if (st.ndig_one)
                    begin
                        state_next = u2rtf_pkg::ST_SPACE;
                    end
                end
            end
            u2rtf_pkg::ST_SPACE:
            begin
                if (emit_ok)
                begin
                    if (st.at_limit || !more)
                    begin
                        state_next = u2rtf_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = u2rtf_pkg::ST_DISPATCH;
                    end
                end
            end
            u2rtf_pkg::ST_PLAIN_BS:
            begin
                if (emit_ok)
                begin
                    state_next = st.at_limit ? u2rtf_pkg::ST_IDLE : u2rtf_pkg::ST_PLAIN;
                end
            end
            u2rtf_pkg::ST_PLAIN:
            begin
                if (emit_ok)
                begin
                    state_next = u2rtf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = u2rtf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.sel        = u2rtf_pkg::SEL_BS;
        in_stall       = 1'b1;
        case (state_reg)
            u2rtf_pkg::ST_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
            end
            u2rtf_pkg::ST_DISPATCH:
            begin
                cmd.accept = 1'b0;
            end
            u2rtf_pkg::ST_LOAD:
            begin
                cmd.esc_load = 1'b1;
            end
            u2rtf_pkg::ST_CONV:
            begin
                cmd.conv_step = 1'b1;
            end
            u2rtf_pkg::ST_BS:
            begin
                cmd.emit = emit_ok;
                cmd.sel  = u2rtf_pkg::SEL_BS;
            end
            u2rtf_pkg::ST_U:
            begin
                cmd.emit = emit_ok;
                cmd.sel  = u2rtf_pkg::SEL_U;
            end
            u2rtf_pkg::ST_MINUS:
            begin
                cmd.emit = emit_ok;
                cmd.sel  = u2rtf_pkg::SEL_MINUS;
            end
            u2rtf_pkg::ST_DIGIT:
            begin
                cmd.emit = emit_ok;
                cmd.sel  = u2rtf_pkg::SEL_DIGIT;
            end
            u2rtf_pkg::ST_SPACE:
            begin
                cmd.emit       = emit_ok;
                cmd.sel        = u2rtf_pkg::SEL_SPACE;
                cmd.final_char = !more;
            end
            u2rtf_pkg::ST_PLAIN_BS:
            begin
                cmd.emit = emit_ok;
                cmd.sel  = u2rtf_pkg::SEL_BS;
            end
            u2rtf_pkg::ST_PLAIN:
            begin
                cmd.emit       = emit_ok;
                cmd.sel        = u2rtf_pkg::SEL_PLAIN;
                cmd.final_char = 1'b1;
            end
            default:
            begin
                cmd.accept = 1'b0;
            end
        endcase
    end

endmodule

### src/u2rtf_dp.sv
// ----------------------------------------------------------------------------
// u2rtf_dp
// Datapath: sequence collector, list of lone bytes to flush, decimal digit
// unit and the output word register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u2rtf_dp
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       in_byte,
    input  logic             end_of_text,
    input  logic             out_stall,
    output logic             out_valid,
    output logic [7:0]       out_char,
    output logic             last_char,
    input  u2rtf_pkg::cmd_t  cmd,
    output u2rtf_pkg::stat_t st
);

    localparam int LIST_W  = $clog2(u2rtf_pkg::LIST_DEPTH + 1);
    localparam int DIG_W   = $clog2(u2rtf_pkg::DIGIT_DEPTH + 1);
    localparam int CNT_W   = $clog2(u2rtf_pkg::OUT_LIMIT + 1);
    localparam int QUOT_W  = 32 - u2rtf_pkg::DIV10_SHIFT;

    // collector state
    logic [7:0]  held_reg [u2rtf_pkg::HELD_DEPTH];
    logic [1:0]  hc_reg;
    logic [1:0]  hc_next;
    logic [2:0]  el_reg;
    logic [2:0]  el_next;

    // flush list and tail of the current word
    logic [7:0]        list_reg [u2rtf_pkg::LIST_DEPTH];
    logic [7:0]        list_next [u2rtf_pkg::LIST_DEPTH];
    logic [LIST_W-1:0] len_reg;
    logic [LIST_W-1:0] len_next;
    logic [LIST_W-1:0] idx_reg;
    u2rtf_pkg::tail_t  tail_reg;
    u2rtf_pkg::tail_t  tail_next;
    logic [7:0]        plain_reg;
    logic              code_neg_reg;
    logic [15:0]       code_mag_reg;

    // escape and digit unit
    logic              esc_neg_reg;
    logic [15:0]       mag_reg;
    logic [3:0]        dig_reg [u2rtf_pkg::DIGIT_DEPTH];
    logic [DIG_W-1:0]  ndig_reg;

    logic [CNT_W-1:0]  cnt_reg;

    logic              out_valid_reg;
    logic [7:0]        out_char_reg;
    logic              last_reg;

    // accept decode
    logic       is_cont;
    logic       complete;
    logic       append;
    logic       flush;
    logic       add_b;
    logic       new_hold;
    logic       plain;
    logic [2:0] ll;
    logic       lead_ok;
    logic [4:0] lead_bits;
    logic [20:0] cp;
    logic [15:0] cp_low;

    logic [31:0]       prod;
    logic [QUOT_W-1:0] quot;
    logic [15:0]       quot_x10;
    logic [15:0]       rem_w;
    logic [7:0]        lone;
    logic [7:0]        char_sel;
    logic              out_free;

    assign is_cont = (in_byte[7:6] == 2'b10);
    assign ll      = u2rtf_pkg::lead_len(in_byte);
    assign lead_ok = (ll != 3'd0) && (32'(ll) <= u2rtf_pkg::MAX_SEQUENCE_BYTES);

    always_comb
    begin
        complete = 1'b0;
        append   = 1'b0;
        flush    = 1'b0;
        add_b    = 1'b0;
        new_hold = 1'b0;
        plain    = 1'b0;
        if (hc_reg != 2'd0 && is_cont && ({1'b0, hc_reg} + 3'd1 >= el_reg))
        begin
            complete = 1'b1;
        end
        else if (hc_reg != 2'd0 && is_cont && hc_reg < 2'(u2rtf_pkg::HELD_DEPTH))
        begin
            append = 1'b1;
            flush  = end_of_text;
            add_b  = end_of_text;
        end
        else if (hc_reg != 2'd0 && is_cont)
        begin
            flush = 1'b1;
            add_b = 1'b1;
        end
        else
        begin
            // broken or no sequence: flush what is held, then take the byte fresh
            flush = 1'b1;
            if (in_byte < u2rtf_pkg::ASCII_LIMIT)
            begin
                plain = 1'b1;
            end
            else if (lead_ok)
            begin
                add_b    = end_of_text;
                new_hold = !end_of_text;
            end
            else
            begin
                add_b = 1'b1;
            end
        end
    end

    always_comb
    begin
        hc_next = hc_reg;
        el_next = el_reg;
        if (new_hold)
        begin
            hc_next = 2'd1;
            el_next = ll;
        end
        else if (append && !flush)
        begin
            hc_next = hc_reg + 2'd1;
        end
        else
        begin
            hc_next = 2'd0;
            el_next = 3'd0;
        end
    end

    always_comb
    begin
        len_next = flush ? (LIST_W'(hc_reg) + LIST_W'(add_b)) : '0;
        for (int i = 0; i < u2rtf_pkg::LIST_DEPTH; i++)
        begin
            if (i < u2rtf_pkg::HELD_DEPTH && 2'(i) < hc_reg)
            begin
                list_next[i] = held_reg[i];
            end
            else
            begin
                list_next[i] = in_byte;
            end
        end
    end

    always_comb
    begin
        if (complete)
        begin
            tail_next = u2rtf_pkg::TAIL_CODE;
        end
        else if (plain)
        begin
            if (in_byte == u2rtf_pkg::CH_BSLASH || in_byte == u2rtf_pkg::CH_LBRACE ||
                in_byte == u2rtf_pkg::CH_RBRACE)
            begin
                tail_next = u2rtf_pkg::TAIL_PLAIN_ESC;
            end
            else
            begin
                tail_next = u2rtf_pkg::TAIL_PLAIN;
            end
        end
        else
        begin
            tail_next = u2rtf_pkg::TAIL_NONE;
        end
    end

    // code point of a finished sequence; only the low 16 bits matter
    always_comb
    begin
        case (el_reg)
            3'd2:    lead_bits = held_reg[0][4:0];
            3'd3:    lead_bits = {1'b0, held_reg[0][3:0]};
            default: lead_bits = {2'b0, held_reg[0][2:0]};
        endcase
        case (hc_reg)
            2'd1:    cp = 21'({lead_bits, in_byte[5:0]});
            2'd2:    cp = 21'({lead_bits, held_reg[1][5:0], in_byte[5:0]});
            default: cp = 21'({lead_bits[2:0], held_reg[1][5:0], held_reg[2][5:0],
                               in_byte[5:0]});
        endcase
    end

    assign cp_low = cp[15:0];

    // divide by ten through the reciprocal
    assign prod     = 32'(mag_reg) * 32'(u2rtf_pkg::DIV10_RECIP);
    assign quot     = prod[31:u2rtf_pkg::DIV10_SHIFT];
    assign quot_x10 = {quot, 3'b0} + {2'b0, quot, 1'b0};
    assign rem_w    = mag_reg - quot_x10;

    assign lone     = list_reg[idx_reg[1:0]];
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hc_reg   <= '0;
            el_reg   <= '0;
            len_reg  <= '0;
            idx_reg  <= '0;
            tail_reg <= u2rtf_pkg::TAIL_NONE;
            ndig_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                hc_reg   <= hc_next;
                el_reg   <= el_next;
                len_reg  <= len_next;
                idx_reg  <= '0;
                tail_reg <= tail_next;
                cnt_reg  <= '0;
            end
            if (cmd.esc_load)
            begin
                ndig_reg <= '0;
                if (idx_reg < len_reg)
                begin
                    idx_reg <= idx_reg + LIST_W'(1);
                end
                else
                begin
                    tail_reg <= u2rtf_pkg::TAIL_NONE;
                end
            end
            if (cmd.conv_step)
            begin
                ndig_reg <= ndig_reg + DIG_W'(1);
            end
            if (cmd.emit)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cmd.sel == u2rtf_pkg::SEL_DIGIT)
                begin
                    ndig_reg <= ndig_reg - DIG_W'(1);
                end
                if (cmd.sel == u2rtf_pkg::SEL_PLAIN)
                begin
                    tail_reg <= u2rtf_pkg::TAIL_NONE;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            if (new_hold)
            begin
                held_reg[0] <= in_byte;
            end
            else if (append)
            begin
                held_reg[hc_reg] <= in_byte;
            end
            for (int i = 0; i < u2rtf_pkg::LIST_DEPTH; i++)
            begin
                list_reg[i] <= list_next[i];
            end
            plain_reg    <= in_byte;
            code_neg_reg <= cp_low[15];
            code_mag_reg <= cp_low[15] ? (~cp_low + 16'd1) : cp_low;
        end
        if (cmd.esc_load)
        begin
            if (idx_reg < len_reg)
            begin
                esc_neg_reg <= lone[7];
                mag_reg     <= lone[7] ? {8'b0, ~lone + 8'd1} : {8'b0, lone};
            end
            else
            begin
                esc_neg_reg <= code_neg_reg;
                mag_reg     <= code_mag_reg;
            end
        end
        if (cmd.conv_step)
        begin
            dig_reg[ndig_reg] <= rem_w[3:0];
            mag_reg           <= 16'(quot);
        end
    end

    always_comb
    begin
        case (cmd.sel)
            u2rtf_pkg::SEL_BS:    char_sel = u2rtf_pkg::CH_BSLASH;
            u2rtf_pkg::SEL_U:     char_sel = u2rtf_pkg::CH_LOWER_U;
            u2rtf_pkg::SEL_MINUS: char_sel = u2rtf_pkg::CH_DASH;
            u2rtf_pkg::SEL_DIGIT: char_sel = u2rtf_pkg::CH_ZERO |
                                             {4'b0, dig_reg[DIG_W'(ndig_reg - DIG_W'(1))]};
            u2rtf_pkg::SEL_SPACE: char_sel = u2rtf_pkg::CH_BLANK;
            u2rtf_pkg::SEL_PLAIN: char_sel = plain_reg;
            default:              char_sel = u2rtf_pkg::CH_BLANK;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_char_reg <= char_sel;
            last_reg     <= cmd.final_char ||
                            (cnt_reg == CNT_W'(u2rtf_pkg::OUT_LIMIT - 1));
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last_char = last_reg;

    assign st.lone_pending = idx_reg < len_reg;
    assign st.tail         = tail_reg;
    assign st.esc_neg      = esc_neg_reg;
    assign st.quot_zero    = (quot == '0);
    assign st.ndig_one     = (ndig_reg == DIG_W'(1));
    assign st.out_free     = out_free;
    assign st.at_limit     = (cnt_reg == CNT_W'(u2rtf_pkg::OUT_LIMIT - 1));

endmodule

### src/utf8_to_rtf_text_escaper.sv
// ----------------------------------------------------------------------------
// utf8_to_rtf_text_escaper
// Turns a UTF-8 byte stream into RTF text: plain ASCII, escaped braces and
// backslash, and \uN escapes for multibyte and invalid bytes.
// ----------------------------------------------------------------------------
// One input byte is taken at a time; the input stalls until every character
// it causes has been loaded into the output word register. A plain character
// is written as it is, after a backslash when it is a brace or a backslash.
// Each \uN escape is set up in the dispatch and load states, its decimal
// digits come from the divide-by-ten unit, then each character is written in
// turn (backslash, u, optional minus, digits, space); a lone byte escape such
// as \u-61 and a negative 5-digit code point go the same way. A byte that
// flushes several held bytes repeats that per escape, up to 24 characters.
// The output register holds one word; a stall on the output side holds the
// sequencer.
`timescale 1ns / 1ps

module utf8_to_rtf_text_escaper
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       end_of_text,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_char,
    output logic       last_char
);

    u2rtf_pkg::cmd_t  cmd;
    u2rtf_pkg::stat_t st;

    u2rtf_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    u2rtf_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_byte     (in_byte),
        .end_of_text (end_of_text),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .out_char    (out_char),
        .last_char   (last_char),
        .cmd         (cmd),
        .st          (st)
    );

endmodule
